[hdl/psfl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfl_pkg: particle slot free list shared definitions
// Pool size, derived widths, command and status codes, sweep bundle.
// ----------------------------------------------------------------------------
package psfl_pkg;

   localparam int POOL_SLOTS = 1024;
   localparam int SLOT_W     = $clog2(POOL_SLOTS);
   localparam int LINK_W     = $clog2(POOL_SLOTS + 1);
   localparam int IDX_W      = 10;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;

   // "none" link: one past the last slot
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_SLOTS);

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SET   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // init sweep toward the memories
   typedef struct packed {
      logic              active;
      logic [SLOT_W-1:0] addr;
      logic [LINK_W-1:0] link;
   } sweep_type;

endpackage

[hdl/psfl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfl_ram: generic single-port RAM
// One address per cycle, write or read; read data registered, held between reads.
// ----------------------------------------------------------------------------
module psfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     wr_en,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/psfl_sweep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfl_sweep: post-reset initialization pass
// Walks every slot once, supplying address and the chained link i+1.
// ----------------------------------------------------------------------------
module psfl_sweep (
   input  logic                 clock,
   input  logic                 reset,
   output psfl_pkg::sweep_type  sweep
);
   import psfl_pkg::*;

   logic              active_ff, active_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (active_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SLOT_W'(POOL_SLOTS - 1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign sweep.active = active_ff;
   assign sweep.addr   = cnt_ff;
   assign sweep.link   = LINK_W'(cnt_ff) + 1'b1;

endmodule

[hdl/particle_slot_free_list_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_slot_free_list_top: linked free-list slot allocator
// Pops, pushes, marks and queries slots of a fixed pool kept in two RAMs.
// ----------------------------------------------------------------------------
// Usage
//   req channel: req_valid/req_ready carry one request (req_command,
//   req_slot_index, req_mark_value). Commands: allocate, free, set mark,
//   query mark. Every request yields exactly one response.
//   rsp channel: rsp_valid/rsp_ready carry the response (rsp_granted_index,
//   rsp_granted, rsp_mark_read, rsp_status).
// Request flow
//   An accepted request moves to the finish state, and its response is
//   registered from there once the output register is free. No new request
//   is taken until then: allocate must read the head slot's next pointer
//   from the link RAM before the following pop can use the new head.
// Reset
//   After reset a sweep writes link[i] = i+1 and clears every valid mark,
//   one slot per cycle; req_ready rises in the cycle after the sweep ends.
//   The list head resets to 0.
// Stall
//   The response register holds while rsp_ready is low; a request already
//   in flight waits in the finish state, and req_ready stays low until the
//   response is placed.
// ----------------------------------------------------------------------------
module particle_slot_free_list_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [psfl_pkg::CMD_W-1:0]         req_command,
   input  logic [psfl_pkg::IDX_W-1:0]         req_slot_index,
   input  logic                               req_mark_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [psfl_pkg::IDX_W-1:0]         rsp_granted_index,
   output logic                               rsp_granted,
   output logic                               rsp_mark_read,
   output logic [psfl_pkg::STATUS_W-1:0]      rsp_status
);
   import psfl_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic              in_range_ff;
   logic              empty_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    gidx_ff, gidx_in;
   logic                gnt_ff, gnt_in;
   logic                mrd_ff, mrd_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;

   sweep_type sweep;

   logic              accept;
   logic              in_range;
   logic              head_empty;
   logic [SLOT_W-1:0] idx_slot;
   logic              out_free;
   logic              finish;

   // link RAM port
   logic [SLOT_W-1:0] nx_addr;
   logic              nx_we, nx_re;
   logic [LINK_W-1:0] nx_wdata, nx_rdata;
   // mark RAM port
   logic [SLOT_W-1:0] mk_addr;
   logic              mk_we, mk_re;
   logic              mk_wdata, mk_rdata;

   psfl_sweep u_sweep (
      .clock (clock),
      .reset (reset),
      .sweep (sweep)
   );

   psfl_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_next_ram (
      .clock   (clock),
      .addr    (nx_addr),
      .wr_en   (nx_we),
      .wr_data (nx_wdata),
      .rd_en   (nx_re),
      .rd_data (nx_rdata)
   );

   psfl_ram #(.WIDTH(1), .DEPTH(POOL_SLOTS)) u_mark_ram (
      .clock   (clock),
      .addr    (mk_addr),
      .wr_en   (mk_we),
      .wr_data (mk_wdata),
      .rd_en   (mk_re),
      .rd_data (mk_rdata)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign in_range   = 32'(req_slot_index) < 32'(POOL_SLOTS);
   assign idx_slot   = SLOT_W'(req_slot_index);
   assign head_empty = (head_ff >= LINK_NONE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign finish     = (state_ff == ST_FINISH) && out_free;

   // Memory access happens in the init sweep or at accept: free/set write, alloc/query read.
   always_comb begin
      nx_addr  = sweep.active ? sweep.addr : idx_slot;
      nx_wdata = sweep.active ? sweep.link : head_ff;
      nx_we    = sweep.active || (accept && req_command == CMD_FREE && in_range);
      nx_re    = accept && req_command == CMD_ALLOC && !head_empty;
      if (!sweep.active && req_command == CMD_ALLOC) begin
         nx_addr = SLOT_W'(head_ff);
      end

      mk_addr  = sweep.active ? sweep.addr : idx_slot;
      mk_wdata = !sweep.active && req_command == CMD_SET && req_mark_value;
      mk_we    = sweep.active ||
                 (accept && in_range && (req_command == CMD_FREE || req_command == CMD_SET));
      mk_re    = accept && req_command == CMD_QUERY && in_range;
   end

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (!sweep.active) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FINISH;
               if (req_command == CMD_FREE && in_range) begin
                  head_in = LINK_W'(idx_slot);   // push
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (cmd_ff == CMD_ALLOC && !empty_ff) begin
                  // pop: new head from link RAM, clamped to none
                  head_in = (nx_rdata >= LINK_NONE) ? LINK_NONE : nx_rdata;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Response assembly in the finish cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      gidx_in      = gidx_ff;
      gnt_in       = gnt_ff;
      mrd_in       = mrd_ff;
      stat_in      = stat_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         gidx_in      = '0;
         gnt_in       = 1'b0;
         mrd_in       = 1'b0;
         stat_in      = ST_OK;
         if (cmd_ff == CMD_ALLOC) begin
            if (empty_ff) begin
               stat_in = ST_EMPTY;
            end else begin
               gidx_in = IDX_W'(head_ff);
               gnt_in  = 1'b1;
            end
         end else if (!in_range_ff) begin
            stat_in = ST_RANGE;
         end else if (cmd_ff == CMD_QUERY) begin
            mrd_in = mk_rdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_command;
         in_range_ff <= in_range;
         empty_ff    <= head_empty;
      end
      gidx_ff <= gidx_in;
      gnt_ff  <= gnt_in;
      mrd_ff  <= mrd_in;
      stat_ff <= stat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = gidx_ff;
   assign rsp_granted       = gnt_ff;
   assign rsp_mark_read     = mrd_ff;
   assign rsp_status        = stat_ff;

`ifndef ASSERT_OFF
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep.active |-> !req_ready)
      else $error("request accepted during init sweep");

   a_head_bounded: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LINK_NONE)
      else $error("list head beyond none link");

   a_accept_to_finish: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_FINISH)
      else $error("accepted request did not reach finish");

   a_finish_responds: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished request produced no response");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_granted |-> rsp_status == ST_OK && !rsp_mark_read)
      else $error("grant with bad status or mark");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: particle slot free list allocator
// Drives allocate / free / set-mark / query-mark requests through the req
// channel with random idling and a long response hold-off. A local model of
// the linked free list predicts each response, and every response is checked
// field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   import psfl_pkg::*;

   localparam int QUIET_LIMIT  = 4000;  // covers the reset sweep and the hold-off
   localparam int HOLD_OFF     = 300;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [IDX_W-1:0]    granted_index;
      logic                granted;
      logic                mark_read;
      logic [STATUS_W-1:0] status;
   } slot_reply_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command    = CMD_ALLOC;
   logic [IDX_W-1:0]    req_slot_index = '0;
   logic                req_mark_value = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [IDX_W-1:0]    rsp_granted_index;
   logic                rsp_granted;
   logic                rsp_mark_read;
   logic [STATUS_W-1:0] rsp_status;

   // model of the allocator: link memory, list head, per-slot valid marks
   logic [LINK_W-1:0] free_link [POOL_SLOTS];
   logic [LINK_W-1:0] free_head;
   logic              slot_mark [POOL_SLOTS];

   slot_reply_type   pending_replies[$];  // predicted responses, oldest first
   logic [IDX_W-1:0] held_slots[$];       // slots currently handed out

   bit idle_on      = 1'b1;  // random idling on both channels
   int hold_left    = 0;     // response hold-off still to run, in cycles
   int quiet_cycles = 0;
   int error_count  = 0;

   particle_slot_free_list_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_slot_index    (req_slot_index),
      .req_mark_value    (req_mark_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_index (rsp_granted_index),
      .rsp_granted       (rsp_granted),
      .rsp_mark_read     (rsp_mark_read),
      .rsp_status        (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Predict the response to one request and advance the model state.
   // Allocate pops the head, free pushes the slot and clears its mark.
   function automatic slot_reply_type predict_reply(input logic [CMD_W-1:0] cmd,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic             mark);
      slot_reply_type r;
      r        = '0;
      r.status = ST_OK;
      if (cmd == CMD_ALLOC) begin
         if (free_head >= LINK_NONE) begin
            r.status = ST_EMPTY;
         end else begin
            r.granted_index = IDX_W'(free_head);
            r.granted       = 1'b1;
            free_head       = free_link[free_head];
            if (free_head > LINK_NONE) begin
               free_head = LINK_NONE;
            end
         end
      end else if (int'(idx) >= POOL_SLOTS) begin
         // cannot happen at this pool size, kept for wider pools
         r.status = ST_RANGE;
      end else if (cmd == CMD_FREE) begin
         slot_mark[idx] = 1'b0;
         free_link[idx] = free_head;
         free_head      = LINK_W'(idx);
      end else if (cmd == CMD_SET) begin
         slot_mark[idx] = mark;
      end else begin
         r.mark_read = slot_mark[idx];
      end
      return r;
   endfunction

   // Offer one request, hold it until accepted, then log its prediction.
   // Valid is only lowered when an idle gap is taken, never re-raised in
   // the same step.
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [IDX_W-1:0] idx,
                               input logic             mark);
      slot_reply_type want;
      int             k;
      while (idle_on && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_slot_index <= idx;
      req_mark_value <= mark;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = predict_reply(cmd, idx, mark);
      pending_replies.insert(pending_replies.size(), want);
      if (want.granted) begin
         held_slots.insert(held_slots.size(), want.granted_index);
      end
      if (cmd == CMD_FREE) begin
         for (k = held_slots.size() - 1; k >= 0; k--) begin
            if (held_slots[k] == idx) held_slots.delete(k);
         end
      end
   endtask

   // Random request. Frees target held slots unless any_free is set, in
   // which case a free may land on a slot already on the list.
   task automatic send_random_request(input bit any_free);
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      int               roll;
      roll = $urandom_range(0, 99);
      if (roll < 30)      cmd = CMD_ALLOC;
      else if (roll < 60) cmd = CMD_FREE;
      else if (roll < 80) cmd = CMD_SET;
      else                cmd = CMD_QUERY;
      idx = IDX_W'($urandom);
      if (held_slots.size() != 0 && $urandom_range(0, 1)) begin
         idx = held_slots[$urandom_range(0, held_slots.size() - 1)];
      end
      if (cmd == CMD_FREE && !(any_free && $urandom_range(0, 99) < 20)) begin
         if (held_slots.size() == 0) begin
            cmd = CMD_ALLOC;
         end else begin
            idx = held_slots[$urandom_range(0, held_slots.size() - 1)];
         end
      end
      send_request(cmd, idx, 1'($urandom));
   endtask

   // Reset state, mark write/read at both ends of the index range, marks
   // surviving allocate, free clearing the mark, LIFO reuse of freed slots.
   task automatic test_directed();
      send_request(CMD_QUERY, 10'd0,    1'b1);
      send_request(CMD_QUERY, 10'd1023, 1'b0);
      send_request(CMD_SET,   10'd1023, 1'b1);
      send_request(CMD_QUERY, 10'd1023, 1'b0);
      send_request(CMD_SET,   10'd1023, 1'b0);
      send_request(CMD_QUERY, 10'd1023, 1'b1);
      send_request(CMD_SET,   10'd0,    1'b1);
      send_request(CMD_ALLOC, 10'd0,    1'b0);
      send_request(CMD_QUERY, 10'd0,    1'b0);
      send_request(CMD_ALLOC, 10'd1023, 1'b1);
      send_request(CMD_SET,   10'd1,    1'b1);
      send_request(CMD_FREE,  10'd0,    1'b1);
      send_request(CMD_QUERY, 10'd0,    1'b0);
      send_request(CMD_ALLOC, 10'h155,  1'b0);
      send_request(CMD_FREE,  10'd1,    1'b0);
      send_request(CMD_QUERY, 10'd1,    1'b0);
      send_request(CMD_ALLOC, 10'h2AA,  1'b1);
      send_request(CMD_SET,   10'h155,  1'b1);
      send_request(CMD_SET,   10'h2AA,  1'b1);
      send_request(CMD_QUERY, 10'h155,  1'b0);
      send_request(CMD_QUERY, 10'h2AA,  1'b1);
   endtask

   // Receiver stops for a long stretch while requests keep coming, so the
   // block fills and holds req_ready low.
   task automatic test_response_hold_off();
      int n;
      hold_left = HOLD_OFF;
      for (n = 0; n < 30; n++) send_random_request(1'b0);
   endtask

   // Mostly allocates until the list runs dry, then allocate on empty.
   task automatic test_drain_pool();
      while (free_head != LINK_NONE) begin
         if ($urandom_range(0, 99) < 92) begin
            send_request(CMD_ALLOC, IDX_W'($urandom), 1'($urandom));
         end else begin
            send_request($urandom_range(0, 1) ? CMD_SET : CMD_QUERY,
                         IDX_W'($urandom), 1'($urandom));
         end
      end
      send_request(CMD_ALLOC, 10'd0,    1'b0);
      send_request(CMD_ALLOC, 10'd1023, 1'b1);
   endtask

   // No idling on either side: full-rate traffic.
   task automatic test_back_to_back();
      int n;
      idle_on = 1'b0;
      for (n = 0; n < 100; n++) send_random_request(1'b0);
      idle_on = 1'b1;
   endtask

   // Mixed traffic where some frees hit slots already on the list.
   task automatic test_random_mix();
      int n;
      for (n = 0; n < 150; n++) send_random_request(1'b1);
   endtask

   // Same slot freed twice in a row: it self-links and is handed out again
   // and again.
   task automatic test_double_free();
      logic [IDX_W-1:0] s;
      send_request(CMD_FREE, 10'd77, 1'b0);
      s = 10'd77;
      send_request(CMD_SET,   s, 1'b1);
      send_request(CMD_FREE,  s, 1'b1);
      send_request(CMD_FREE,  s, 1'b0);
      send_request(CMD_ALLOC, s, 1'b0);
      send_request(CMD_ALLOC, s, 1'b1);
      send_request(CMD_QUERY, s, 1'b0);
   endtask

   // Receiver: random stalls, or a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(0, 99) < 24);
      end
   end

   // Response checker: each accepted response against the oldest prediction.
   always @(posedge clock) begin : check_replies
      slot_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $error("response with no request pending");
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_granted_index !== want.granted_index) begin
               $error("granted_index: expected %0d, actual %0d",
                      want.granted_index, rsp_granted_index);
               error_count++;
            end
            if (rsp_granted !== want.granted) begin
               $error("granted: expected %0d, actual %0d", want.granted, rsp_granted);
               error_count++;
            end
            if (rsp_mark_read !== want.mark_read) begin
               $error("mark_read: expected %0d, actual %0d",
                      want.mark_read, rsp_mark_read);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too many cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int i;
      for (i = 0; i < POOL_SLOTS; i++) begin
         free_link[i] = LINK_W'(i + 1);
         slot_mark[i] = 1'b0;
      end
      free_head = '0;

      // once reset is released the block sweeps its RAMs with
      // req_ready low, which the first request simply waits out
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_response_hold_off();
      test_drain_pool();
      test_back_to_back();
      test_random_mix();
      test_double_free();

      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
